// File: sv/three_line_audio_serializer_fifo_defines.svh
// assertion helpers for the serializer block
`ifndef THREE_LINE_AUDIO_SERIALIZER_FIFO_DEFINES_SVH
`define THREE_LINE_AUDIO_SERIALIZER_FIFO_DEFINES_SVH

`ifndef ASSERT_OFF
// condition implies consequence in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// condition implies consequence in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: sv/tlas_pkg.sv
package tlas_pkg;

   // sizes fixed by the serial format
   localparam int SAMPLE_W       = 32;
   localparam int FRAME_BITS     = 64;
   localparam int LEVEL_W        = 11;
   localparam int FIFO_DEPTH_DEF = 1024;

   // last bit index of a frame, sent first
   localparam logic [5:0] FRAME_LAST = 6'(FRAME_BITS - 1);

   // response queue depth and index width
   localparam int OQ_DEPTH = 3;
   localparam int OQ_IDX_W = 2;

   // request kinds
   localparam logic KIND_ENQUEUE = 1'b0;
   localparam logic KIND_TICK    = 1'b1;

   typedef struct packed {
      logic                kind;
      logic [SAMPLE_W-1:0] left_a;
      logic [SAMPLE_W-1:0] right_a;
      logic [SAMPLE_W-1:0] left_b;
      logic [SAMPLE_W-1:0] right_b;
      logic [SAMPLE_W-1:0] left_c;
      logic [SAMPLE_W-1:0] right_c;
   } req_type;

   typedef struct packed {
      logic               bit_clock;
      logic               frame_clock;
      logic               data_line_a;
      logic               data_line_b;
      logic               data_line_c;
      logic               enqueue_dropped;
      logic               underrun;
      logic [LEVEL_W-1:0] fifo_level;
   } rsp_type;

   // one stored sample set, one word per data line
   typedef struct packed {
      logic [FRAME_BITS-1:0] a;
      logic [FRAME_BITS-1:0] b;
      logic [FRAME_BITS-1:0] c;
   } line_type;

   // control handed from the accept stage to the shift stage
   typedef struct packed {
      logic       rise;
      logic       load;
      logic [5:0] bit_sel;
      rsp_type    rsp;
   } stage_type;

endpackage

// File: sv/tlas_ram.sv
module tlas_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: sv/three_line_audio_serializer_fifo.sv
// channel   ports                         moves
// --------  ----------------------------  ---------------------------------------
// request   req_valid req_ready req_data  enqueue of one sample set, or half tick
// response  rsp_valid rsp_ready rsp_data  clock and pin levels, flags, fifo level
//
// one request per cycle while req_ready is high; its response reaches rsp_valid
// after the sample memory read and shift stage register, then the response queue
// the sample memory has one write and one read port, at most one access per request
// reset clears pointers, level, shift words and pins; the sample memory is not cleared
// response stalls are absorbed by the queue; req_ready drops only when it fills
`include "three_line_audio_serializer_fifo_defines.svh"

module three_line_audio_serializer_fifo #(
   parameter int FIFO_DEPTH = tlas_pkg::FIFO_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tlas_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tlas_pkg::rsp_type rsp_data
);

   import tlas_pkg::*;

   localparam int ADDR_W = $clog2(FIFO_DEPTH);
   localparam int LVL_W  = $clog2(FIFO_DEPTH + 1);
   localparam int LVL_XW = (LVL_W > LEVEL_W) ? LVL_W : LEVEL_W;
   localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(FIFO_DEPTH - 1);
   localparam logic [LVL_W-1:0]  FULL_LVL  = LVL_W'(FIFO_DEPTH);

   // fifo control
   logic [ADDR_W-1:0] wr_slot_ff, wr_slot_in;
   logic [ADDR_W-1:0] rd_slot_ff, rd_slot_in;
   logic [LVL_W-1:0]  level_ff, level_in;
   logic [LVL_XW-1:0] level_ext;
   logic [6:0]        bpos_ff, bpos_in;
   logic              clk_hi_ff, clk_hi_in;

   // accept stage decode
   logic       accept, is_tick, full, empty, frame_start;
   logic       rise, push, drop, load, under;
   logic [5:0] bit_sel;

   // shift stage
   logic      s1_valid_ff;
   stage_type s1_ff, s1_in;
   line_type  shift_ff, shift_in, line_now, wr_line, rd_line;
   logic      frame_ff, frame_in;
   logic [2:0] dline_ff, dline_in;
   rsp_type   rsp_new;

   // response queue
   rsp_type               oq_ff [OQ_DEPTH];
   logic [OQ_IDX_W-1:0]   oq_head_ff, oq_head_in;
   logic [OQ_IDX_W-1:0]   oq_count_ff, oq_count_in;
   logic [OQ_IDX_W:0]     oq_wsum, oq_used;
   logic [OQ_IDX_W-1:0]   oq_widx;
   logic                  oq_pop;

   // sample memory
   logic ram_wr_en, ram_rd_en;

   // request decode
   always_comb begin
      accept      = req_valid & req_ready;
      is_tick     = (req_data.kind == KIND_TICK);
      full        = (level_ff == FULL_LVL);
      empty       = (level_ff == '0);
      frame_start = bpos_ff[6];
      rise        = is_tick & ~clk_hi_ff;
      push        = ~is_tick & ~full;
      drop        = ~is_tick & full;
      load        = rise & frame_start & ~empty;
      under       = rise & frame_start & empty;
      bit_sel     = frame_start ? FRAME_LAST : bpos_ff[5:0];
   end

   // pointer, level and bit clock update
   always_comb begin
      wr_slot_in = wr_slot_ff;
      rd_slot_in = rd_slot_ff;
      level_in   = level_ff;
      bpos_in    = bpos_ff;
      clk_hi_in  = clk_hi_ff;
      if (accept) begin
         if (push) begin
            wr_slot_in = (wr_slot_ff == LAST_SLOT) ? '0 : wr_slot_ff + 1'b1;
            level_in   = level_ff + 1'b1;
         end
         if (load) begin
            rd_slot_in = (rd_slot_ff == LAST_SLOT) ? '0 : rd_slot_ff + 1'b1;
            level_in   = level_ff - 1'b1;
         end
         if (is_tick) begin
            clk_hi_in = ~clk_hi_ff;
         end
         if (rise) begin
            bpos_in = {1'b0, bit_sel} - 7'd1;
         end
      end
   end

   // memory access and stage record
   always_comb begin
      ram_wr_en = accept & push;
      ram_rd_en = accept & load;
      wr_line.a = {req_data.left_a, req_data.right_a};
      wr_line.b = {req_data.left_b, req_data.right_b};
      wr_line.c = {req_data.left_c, req_data.right_c};
      level_ext = LVL_XW'(level_in);

      s1_in.rise                = rise;
      s1_in.load                = load;
      s1_in.bit_sel             = bit_sel;
      s1_in.rsp.bit_clock       = clk_hi_in;
      s1_in.rsp.frame_clock     = 1'b0;
      s1_in.rsp.data_line_a     = 1'b0;
      s1_in.rsp.data_line_b     = 1'b0;
      s1_in.rsp.data_line_c     = 1'b0;
      s1_in.rsp.enqueue_dropped = drop;
      s1_in.rsp.underrun        = under;
      s1_in.rsp.fifo_level      = level_ext[LEVEL_W-1:0];
   end

   tlas_ram #(
      .WIDTH ($bits(line_type)),
      .DEPTH (FIFO_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_slot_ff),
      .wr_data (wr_line),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_slot_ff),
      .rd_data (rd_line)
   );

   // shift stage: load the frame words and drive the pins on a rising half
   always_comb begin
      line_now = s1_ff.load ? rd_line : shift_ff;
      shift_in = shift_ff;
      frame_in = frame_ff;
      dline_in = dline_ff;
      if (s1_valid_ff && s1_ff.rise) begin
         shift_in = line_now;
         frame_in = s1_ff.bit_sel[5];
         dline_in = {line_now.a[s1_ff.bit_sel],
                     line_now.b[s1_ff.bit_sel],
                     line_now.c[s1_ff.bit_sel]};
      end
      rsp_new             = s1_ff.rsp;
      rsp_new.frame_clock = frame_in;
      rsp_new.data_line_a = dline_in[2];
      rsp_new.data_line_b = dline_in[1];
      rsp_new.data_line_c = dline_in[0];
   end

   // response queue bookkeeping
   always_comb begin
      rsp_valid   = (oq_count_ff != '0);
      rsp_data    = oq_ff[oq_head_ff];
      oq_pop      = rsp_valid & rsp_ready;
      oq_wsum     = {1'b0, oq_head_ff} + {1'b0, oq_count_ff};
      oq_widx     = (oq_wsum >= (OQ_IDX_W+1)'(OQ_DEPTH))
                  ? OQ_IDX_W'(oq_wsum - (OQ_IDX_W+1)'(OQ_DEPTH))
                  : oq_wsum[OQ_IDX_W-1:0];
      oq_head_in  = oq_head_ff;
      if (oq_pop) begin
         oq_head_in = (oq_head_ff == OQ_IDX_W'(OQ_DEPTH - 1)) ? '0 : oq_head_ff + 1'b1;
      end
      oq_count_in = oq_count_ff + OQ_IDX_W'(s1_valid_ff) - OQ_IDX_W'(oq_pop);
      oq_used     = {1'b0, oq_count_ff} + (OQ_IDX_W+1)'(s1_valid_ff);
      req_ready   = (oq_used < (OQ_IDX_W+1)'(OQ_DEPTH));
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_slot_ff  <= '0;
         rd_slot_ff  <= '0;
         level_ff    <= '0;
         bpos_ff     <= '1;
         clk_hi_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
         shift_ff    <= '0;
         frame_ff    <= 1'b0;
         dline_ff    <= '0;
         oq_head_ff  <= '0;
         oq_count_ff <= '0;
      end else begin
         wr_slot_ff  <= wr_slot_in;
         rd_slot_ff  <= rd_slot_in;
         level_ff    <= level_in;
         bpos_ff     <= bpos_in;
         clk_hi_ff   <= clk_hi_in;
         s1_valid_ff <= accept;
         shift_ff    <= shift_in;
         frame_ff    <= frame_in;
         dline_ff    <= dline_in;
         oq_head_ff  <= oq_head_in;
         oq_count_ff <= oq_count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      if (s1_valid_ff) begin
         oq_ff[oq_widx] <= rsp_new;
      end
   end

   // checks
   `ASSERT_IMPLY(a_oq_room, clock, reset, s1_valid_ff, oq_count_ff < OQ_IDX_W'(OQ_DEPTH), "response queue overflow")
   `ASSERT_IMPLY(a_level_max, clock, reset, 1'b1, level_ff <= FULL_LVL, "fifo level above depth")
   `ASSERT_IMPLY(a_no_write_full, clock, reset, ram_wr_en, level_ff != FULL_LVL, "write into full fifo")
   `ASSERT_IMPLY(a_no_read_empty, clock, reset, ram_rd_en, level_ff != '0, "read from empty fifo")
   `ASSERT_NEXT(a_load_follows_read, clock, reset, ram_rd_en, s1_valid_ff && s1_ff.load, "frame load lost")

endmodule
